// ===== hdl/miu_pkg.sv =====
// Package for the modular inverse unit.
// Holds the sequencer state type; no dependencies.
`default_nettype none

package miu_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_SUB,
    ST_FINAL
  } miu_state_e;

endpackage

`default_nettype wire

// ===== hdl/modular_inverse_unit_core.sv =====
// Modular inverse unit: extended Euclid with a shared shift/compare/subtract divider.
// Sequence: reduction of the value mod the modulus, then one divider pass per Euclid step
//   (each pass aligns the divisor, then subtracts bit by bit), then a final check.
// One request at a time: a new one is taken only after the result is written. A request may be
//   accepted while the previous result still waits in the output register.
// Reset: asynchronous, active low; returns to idle, modulus resets to 3, output empty.
`default_nettype none

module modular_inverse_unit_core
  import miu_pkg::*;
#(
  parameter int unsigned WIDTH = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             modulus_we_i,
  input  wire logic [WIDTH-1:0] modulus_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [WIDTH-1:0] value_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [WIDTH-1:0]      inverse_o,
  output logic                  no_inverse_o
);

  localparam int unsigned KW = $clog2(WIDTH);

  miu_state_e       state_q, state_d;
  logic [WIDTH-1:0] mod_q;
  logic             reduce_q, reduce_d;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] nr_q, nr_d;
  logic [WIDTH-1:0] ds_q, ds_d;
  logic [WIDTH-1:0] cs_q, cs_d;
  logic [WIDTH-1:0] tm_q, tm_d;
  logic [WIDTH-1:0] ntm_q, ntm_d;
  logic [WIDTH-1:0] acc_q, acc_d;
  logic             tneg_q, tneg_d;
  logic             ntneg_q, ntneg_d;
  logic [KW-1:0]    k_q, k_d;
  logic             out_valid_q, out_valid_d;
  logic [WIDTH-1:0] out_inv_q, out_inv_d;
  logic             out_flag_q, out_flag_d;

  // shared compare/subtract unit
  logic [WIDTH:0]   sub_b;
  logic [WIDTH+1:0] diff;
  logic             ge;
  logic [WIDTH-1:0] rem_next;
  logic [WIDTH-1:0] acc_sum;
  logic [WIDTH-1:0] tm_eff;
  logic [WIDTH-1:0] inv_val;

  always_comb begin
    sub_b    = (state_q == ST_ALIGN) ? {ds_q, 1'b0} : {1'b0, ds_q};
    diff     = {2'b00, rem_q} - {1'b0, sub_b};
    ge       = ~diff[WIDTH+1];
    rem_next = ge ? diff[WIDTH-1:0] : rem_q;
    acc_sum  = ge ? (acc_q + cs_q) : acc_q;
    tm_eff   = (tm_q == mod_q) ? '0 : tm_q;
    inv_val  = (tneg_q && (tm_eff != '0)) ? (mod_q - tm_eff) : tm_eff;
  end

  always_comb begin
    state_d     = state_q;
    reduce_d    = reduce_q;
    rem_d       = rem_q;
    nr_d        = nr_q;
    ds_d        = ds_q;
    cs_d        = cs_q;
    tm_d        = tm_q;
    ntm_d       = ntm_q;
    acc_d       = acc_q;
    tneg_d      = tneg_q;
    ntneg_d     = ntneg_q;
    k_d         = k_q;
    out_valid_d = out_valid_q;
    out_inv_d   = out_inv_q;
    out_flag_d  = out_flag_q;
    in_stall_o  = (state_q != ST_IDLE);

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          rem_d    = value_i;
          ds_d     = mod_q;
          k_d      = '0;
          reduce_d = 1'b1;
          if (mod_q == '0) begin
            // no modulus: flag it through the final check
            rem_d   = '0;
            state_d = ST_FINAL;
          end else begin
            state_d = ST_ALIGN;
          end
        end
      end

      ST_ALIGN: begin
        if (!ds_q[WIDTH-1] && ge) begin
          ds_d = {ds_q[WIDTH-2:0], 1'b0};
          cs_d = {cs_q[WIDTH-2:0], 1'b0};
          k_d  = k_q + 1'b1;
        end else begin
          state_d = ST_SUB;
        end
      end

      ST_SUB: begin
        rem_d = rem_next;
        acc_d = acc_sum;
        if (k_q != '0) begin
          ds_d = {1'b0, ds_q[WIDTH-1:1]};
          cs_d = {1'b0, cs_q[WIDTH-1:1]};
          k_d  = k_q - 1'b1;
        end else begin
          k_d = '0;
          if (reduce_q) begin
            // reduction done: start Euclid with r = m, nr = value mod m
            reduce_d = 1'b0;
            rem_d    = mod_q;
            nr_d     = rem_next;
            ds_d     = rem_next;
            tm_d     = '0;
            tneg_d   = 1'b1;
            ntm_d    = {{(WIDTH-1){1'b0}}, 1'b1};
            ntneg_d  = 1'b0;
            cs_d     = {{(WIDTH-1){1'b0}}, 1'b1};
            acc_d    = '0;
          end else begin
            // advance one Euclid step
            rem_d   = nr_q;
            nr_d    = rem_next;
            ds_d    = rem_next;
            tm_d    = ntm_q;
            tneg_d  = ntneg_q;
            ntm_d   = acc_sum;
            ntneg_d = ~ntneg_q;
            cs_d    = acc_sum;
            acc_d   = ntm_q;
          end
          state_d = (rem_next == '0) ? ST_FINAL : ST_ALIGN;
        end
      end

      ST_FINAL: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          if (rem_q != {{(WIDTH-1){1'b0}}, 1'b1}) begin
            out_inv_d  = '0;
            out_flag_d = 1'b1;
          end else begin
            out_inv_d  = inv_val;
            out_flag_d = 1'b0;
          end
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      reduce_q    <= 1'b0;
      out_valid_q <= 1'b0;
      mod_q       <= WIDTH'(3);
    end else begin
      state_q     <= state_d;
      reduce_q    <= reduce_d;
      out_valid_q <= out_valid_d;
      if (modulus_we_i) begin
        mod_q <= modulus_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    nr_q      <= nr_d;
    ds_q      <= ds_d;
    cs_q      <= cs_d;
    tm_q      <= tm_d;
    ntm_q     <= ntm_d;
    acc_q     <= acc_d;
    tneg_q    <= tneg_d;
    ntneg_q   <= ntneg_d;
    k_q       <= k_d;
    out_inv_q <= out_inv_d;
    out_flag_q <= out_flag_d;
  end

  assign out_valid_o  = out_valid_q;
  assign inverse_o    = out_inv_q;
  assign no_inverse_o = out_flag_q;

endmodule

`default_nettype wire

// ===== verif/modular_inverse_unit_core_tb.sv =====
// Testbench for modular_inverse_unit_core: random and directed values under several moduli.
// A scoreboard class predicts each inverse with its own extended Euclid.
// Depends only on the RTL of the block.
module modular_inverse_unit_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = 64;
  localparam logic [W-1:0] ALL_ONES = '1;
  localparam logic [W-1:0] TOP_PRIME = 64'hFFFF_FFFF_FFFF_FFC5;

  typedef struct packed {
    logic [W-1:0] inverse;
    logic         no_inv;
  } inv_result_t;

  class inverse_book;
    inv_result_t  pending_inverses[$];
    logic [W-1:0] modulus = W'(3);
    int           mismatches = 0;

    function void set_modulus(logic [W-1:0] m);
      modulus = m;
    endfunction

    // Extended Euclid with the Bezout coefficient kept as magnitude plus sign.
    function inv_result_t predict_inverse(logic [W-1:0] val, logic [W-1:0] m);
      logic [W-1:0] rem, nrem, coef, ncoef, tmp, quo;
      bit           neg, nneg;
      inv_result_t  res;
      res = '0;
      if (m == '0) begin
        res.no_inv = 1'b1;
        return res;
      end
      rem = m;
      nrem = val % m;
      coef = '0;
      neg = 1'b1;
      ncoef = W'(1);
      nneg = 1'b0;
      while (nrem != '0) begin
        quo = rem / nrem;
        tmp = coef + quo * ncoef;
        coef = ncoef;
        neg = nneg;
        ncoef = tmp;
        nneg = !nneg;
        tmp = rem - quo * nrem;
        rem = nrem;
        nrem = tmp;
      end
      if (rem != W'(1)) begin
        res.no_inv = 1'b1;
        return res;
      end
      coef = coef % m;
      res.inverse = (neg && coef != '0) ? m - coef : coef;
      return res;
    endfunction

    function void log_request(logic [W-1:0] val);
      pending_inverses.insert(pending_inverses.size(), predict_inverse(val, modulus));
    endfunction

    function void check_result(logic [W-1:0] inverse, logic no_inverse);
      inv_result_t want;
      if (pending_inverses.size() == 0) begin
        $display("%0t: unexpected result inverse=%h no_inverse=%b", $time, inverse, no_inverse);
        mismatches++;
        return;
      end
      want = pending_inverses.pop_front();
      if (inverse !== want.inverse) begin
        $display("%0t: inverse expected %h actual %h", $time, want.inverse, inverse);
        mismatches++;
      end
      if (no_inverse !== want.no_inv) begin
        $display("%0t: no_inverse expected %b actual %b", $time, want.no_inv, no_inverse);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return pending_inverses.size();
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni = 1'b0;
  logic         modulus_we_i = 1'b0;
  logic [W-1:0] modulus_i = '0;
  logic         in_valid_i = 1'b0;
  logic         in_stall_o;
  logic [W-1:0] value_i = '0;
  logic         out_valid_o;
  logic         out_stall_i = 1'b0;
  logic [W-1:0] inverse_o;
  logic         no_inverse_o;

  inverse_book book = new;
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;

  modular_inverse_unit_core #(
    .WIDTH(W)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .modulus_we_i(modulus_we_i),
    .modulus_i   (modulus_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .inverse_o   (inverse_o),
    .no_inverse_o(no_inverse_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("modular_inverse_unit_core test failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) book.log_request(value_i);
      if (out_valid_o && !out_stall_i) book.check_result(inverse_o, no_inverse_o);
    end
  end

  // Result side: random stall before each result outside burst phases, one long hold-off to back the block up.
  initial begin
    int hold;
    int taken;
    taken = 0;
    forever begin
      hold = rx_burst ? 0 : int'($urandom_range(0, 13));
      if (taken == 300) hold = 5000;
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(rst_ni && out_valid_o));
      taken++;
    end
  end

  function automatic logic [W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [W-1:0] random_modulus();
    logic [W-1:0] m;
    case ($urandom_range(0, 4))
      0: m = rand_word();
      1: m = W'($urandom_range(2, 1000));
      2: m = W'(1) << $urandom_range(1, 63);
      3: m = (rand_word() >> $urandom_range(0, 60)) | W'(1);
      default: m = W'($urandom);
    endcase
    if (m < W'(2)) m = W'(2);
    return m;
  endfunction

  function automatic logic [W-1:0] random_value(logic [W-1:0] m);
    case ($urandom_range(0, 9))
      6: return W'($urandom_range(0, 1000));
      7: return m * W'($urandom_range(0, 5)) + W'($urandom_range(0, 2));
      8: return m - W'($urandom_range(0, 3));
      9: return rand_word() >> $urandom_range(1, 63);
      default: return rand_word();
    endcase
  endfunction

  // Offer one request after a random gap; return at the edge that takes it.
  task automatic send_value(logic [W-1:0] val);
    int gap;
    gap = tx_burst ? 0 : int'($urandom_range(0, 13));
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i <= val;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drop the request line and hold until every result is back.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (book.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic write_modulus(logic [W-1:0] m);
    modulus_we_i <= 1'b1;
    modulus_i <= m;
    @(posedge clk_i);
    modulus_we_i <= 1'b0;
    book.set_modulus(m);
  endtask

  initial begin
    logic [W-1:0] m;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset modulus of three, including a multiple of it.
    send_value('0);
    send_value(W'(1));
    send_value(W'(2));
    send_value(W'(3));
    send_value(W'(4));
    send_value(ALL_ONES);
    send_value(W'(1) << 63);
    drain();
    // Modulus one: everything maps to zero with no flag.
    write_modulus(W'(1));
    send_value('0);
    send_value(W'(5));
    send_value(ALL_ONES);
    drain();
    // Modulus zero: flag every request.
    write_modulus('0);
    send_value('0);
    send_value(W'(1));
    send_value(W'(7));
    drain();
    write_modulus(ALL_ONES);
    send_value(ALL_ONES);
    send_value(ALL_ONES - 1);
    send_value(W'(1));
    send_value(W'(3));
    send_value(W'(2));
    drain();
    write_modulus(W'(2));
    send_value('0);
    send_value(W'(1));
    send_value(ALL_ONES);
    drain();
    write_modulus(TOP_PRIME);
    send_value(TOP_PRIME - 1);
    send_value(W'(1) << 63);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      m = (ph == 0) ? ALL_ONES : (ph == 1) ? W'(2) : random_modulus();
      tx_burst = (ph % 3 == 1);
      rx_burst = (ph % 4 == 2);
      write_modulus(m);
      for (int k = 0; k < 108; k++) send_value(random_value(m));
      drain();
    end

    repeat (6 * W + 16) @(posedge clk_i);
    if (book.mismatches == 0 && book.outstanding() == 0) begin
      $display("modular_inverse_unit_core test passed");
    end else begin
      if (book.outstanding() != 0)
        $display("%0t: %0d results never arrived", $time, book.outstanding());
      $display("modular_inverse_unit_core test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/miu_pkg.sv
hdl/modular_inverse_unit_core.sv
verif/modular_inverse_unit_core_tb.sv
